// ----- rtl/core/pcar_pkg.sv -----
// Shared types and constants of the packet checksum acknowledge receiver.
package pcar_pkg;

   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 6;
   localparam int SUM_W      = 18;
   localparam int CHECKSUM_W = 32;
   localparam int ACTION_W   = 3;
   localparam int EVENT_W    = 3;
   localparam int PHASE_W    = 2;
   localparam int TERM_W     = BYTE_W + 2;

   // Division by three of a byte: multiply by 171 and drop nine bits (exact for 0..255).
   localparam logic [BYTE_W-1:0] DIV3_MUL   = 8'd171;
   localparam int                DIV3_SHIFT = 9;

   typedef enum logic [ACTION_W-1:0] {
      ACT_DATA      = 3'd0,
      ACT_LAST_DATA = 3'd1,
      ACT_ACK       = 3'd2,
      ACT_NACK      = 3'd3,
      ACT_TERM      = 3'd4
   } action_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_SEND_ACK    = 3'd0,
      EV_SEND_NACK   = 3'd1,
      EV_DELIVER     = 3'd2,
      EV_ACK_SEEN    = 3'd3,
      EV_NACK_SEEN   = 3'd4,
      EV_LINK_CLOSED = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             match;
   } csum_type;

endpackage

// ----- rtl/core/pcar_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
interface pcar_req_if;
   logic                                valid;
   logic                                ready;
   logic [pcar_pkg::ACTION_W-1:0]       action;
   logic [pcar_pkg::BYTE_W-1:0]         data_byte;
   logic                                byte_last;
   logic [pcar_pkg::CHECKSUM_W-1:0]     sent_checksum;

   modport source (output valid, action, data_byte, byte_last, sent_checksum, input ready);
   modport sink   (input valid, action, data_byte, byte_last, sent_checksum, output ready);
endinterface

interface pcar_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pcar_pkg::EVENT_W-1:0]  event_res;
   logic [pcar_pkg::BYTE_W-1:0]   out_byte;
   logic                          message_end;
   logic                          run_last;

   modport source (output valid, event_res, out_byte, message_end, run_last, input ready);
   modport sink   (input valid, event_res, out_byte, message_end, run_last, output ready);
endinterface

// ----- rtl/core/pcar_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module pcar_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pcar_csum.sv -----
// Checksum update for one byte and the compare against the sent checksum.
module pcar_csum (
   input  logic [pcar_pkg::SUM_W-1:0]      sum,
   input  logic [pcar_pkg::PHASE_W-1:0]    phase,
   input  logic [pcar_pkg::BYTE_W-1:0]     data_byte,
   input  logic                            add_en,
   input  logic [pcar_pkg::CHECKSUM_W-1:0] sent_checksum,
   output pcar_pkg::csum_type              result
);

   localparam int PROD_W = 2 * pcar_pkg::BYTE_W;

   logic [PROD_W-1:0]             prod;
   logic [pcar_pkg::TERM_W-1:0]   times3;
   logic [pcar_pkg::TERM_W-1:0]   div3;
   logic [pcar_pkg::TERM_W-1:0]   term;
   logic [pcar_pkg::SUM_W-1:0]    sum_next;

   always_comb begin
      prod   = PROD_W'(data_byte) * PROD_W'(pcar_pkg::DIV3_MUL);
      div3   = pcar_pkg::TERM_W'(prod >> pcar_pkg::DIV3_SHIFT);
      times3 = pcar_pkg::TERM_W'(data_byte) + pcar_pkg::TERM_W'({data_byte, 1'b0});
      // The first two bytes of a group of four count triple, the other two a third.
      term     = (phase < pcar_pkg::PHASE_W'(2)) ? times3 : div3;
      sum_next = add_en ? (sum + pcar_pkg::SUM_W'(term)) : sum;
      result.sum   = sum_next;
      result.match = ({(pcar_pkg::CHECKSUM_W - pcar_pkg::SUM_W)'(0), sum_next} == sent_checksum);
   end

endmodule

// ----- rtl/core/packet_checksum_ack_receiver.sv -----
// Top level: stop-and-wait receiver that buffers a packet, checks its sum and acknowledges it.
// A data byte that does not close a packet leaves the receiver idle, so req ready stays high.
// A closing byte with a good checksum delivers the n buffered bytes, each fetched from the byte
// buffer in ST_READ and sent from ST_EMIT, then the ack.
// A nack, ack seen, nack seen or link closed result goes via ST_FINAL into the response register.
// Synchronous reset opens the link and empties the packet; the byte buffer is not cleared.
module packet_checksum_ack_receiver #(
   parameter int PAYLOAD_MAX = 32
) (
   input  logic       clock,
   input  logic       reset,
   pcar_req_if.sink   req_ch,
   pcar_rsp_if.source rsp_ch
);

   localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
   localparam int CW = pcar_pkg::COUNT_W;

   // Control state of the receiver.
   pcar_pkg::state_type               state_ff, state_in;
   logic                              link_alive_ff, link_alive_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [pcar_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [pcar_pkg::PHASE_W-1:0]      phase_ff, phase_in;

   // Delivery sequencing: number of bytes to deliver and the current read index.
   logic [CW-1:0]                     len_ff, len_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   pcar_pkg::event_type               fin_ev_ff, fin_ev_in;
   logic                              fin_mend_ff, fin_mend_in;

   // Response output register, which lets the next transaction in while a result waits.
   logic                              rsp_valid_ff, rsp_valid_in;
   pcar_pkg::event_type               ev_ff, ev_in;
   logic [pcar_pkg::BYTE_W-1:0]       byte_ff, byte_in;
   logic                              mend_ff, mend_in;
   logic                              last_ff, last_in;

   logic                              accept;
   logic                              room;
   logic                              out_free;
   logic                              wr_en;
   logic                              rd_en;
   logic [pcar_pkg::BYTE_W-1:0]       rd_data;
   logic [CW-1:0]                     idx_next;
   logic [CW-1:0]                     count_next;
   pcar_pkg::csum_type                csum;

   assign req_ch.ready = (state_ff == pcar_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign room         = (count_ff < CW'(PAYLOAD_MAX));
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign idx_next     = idx_ff + CW'(1);
   assign count_next   = count_ff + CW'(1);

   // Packet bytes live in the buffer memory, written in arrival order.
   pcar_ram #(
      .WIDTH (pcar_pkg::BYTE_W),
      .DEPTH (PAYLOAD_MAX),
      .ADDR_W(AW)
   ) u_pcar_buf (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_ch.data_byte),
      .rd_en  (rd_en),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   // Running checksum; a byte that finds the buffer full is neither stored nor summed.
   pcar_csum u_pcar_csum (
      .sum          (sum_ff),
      .phase        (phase_ff),
      .data_byte    (req_ch.data_byte),
      .add_en       (room),
      .sent_checksum(req_ch.sent_checksum),
      .result       (csum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcar_pkg::ST_IDLE;
         link_alive_ff <= 1'b1;
         count_ff      <= '0;
         sum_ff        <= '0;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         link_alive_ff <= link_alive_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      fin_ev_ff   <= fin_ev_in;
      fin_mend_ff <= fin_mend_in;
      ev_ff       <= ev_in;
      byte_ff     <= byte_in;
      mend_ff     <= mend_in;
      last_ff     <= last_in;
   end

   always_comb begin
      state_in      = state_ff;
      link_alive_in = link_alive_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      phase_in      = phase_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      fin_ev_in     = fin_ev_ff;
      fin_mend_in   = fin_mend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      ev_in         = ev_ff;
      byte_in       = byte_ff;
      mend_in       = mend_ff;
      last_in       = last_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      unique case (state_ff)
         pcar_pkg::ST_IDLE: begin
            // A closed link swallows every transaction without a result.
            if (accept && link_alive_ff) begin
               unique case (req_ch.action)
                  pcar_pkg::ACT_DATA, pcar_pkg::ACT_LAST_DATA: begin
                     if (room) begin
                        wr_en    = 1'b1;
                        count_in = count_next;
                        sum_in   = csum.sum;
                        phase_in = phase_ff + pcar_pkg::PHASE_W'(1);
                     end
                     // The byte marked last closes the packet, whatever its fill level.
                     if (req_ch.byte_last) begin
                        count_in = '0;
                        sum_in   = '0;
                        phase_in = '0;
                        if (csum.match) begin
                           len_in      = room ? count_next : count_ff;
                           idx_in      = '0;
                           fin_ev_in   = pcar_pkg::EV_SEND_ACK;
                           fin_mend_in = (req_ch.action == pcar_pkg::ACT_LAST_DATA);
                           state_in    = pcar_pkg::ST_READ;
                        end else begin
                           fin_ev_in   = pcar_pkg::EV_SEND_NACK;
                           fin_mend_in = 1'b0;
                           state_in    = pcar_pkg::ST_FINAL;
                        end
                     end
                  end
                  pcar_pkg::ACT_ACK: begin
                     fin_ev_in   = pcar_pkg::EV_ACK_SEEN;
                     fin_mend_in = 1'b0;
                     state_in    = pcar_pkg::ST_FINAL;
                  end
                  pcar_pkg::ACT_NACK: begin
                     fin_ev_in   = pcar_pkg::EV_NACK_SEEN;
                     fin_mend_in = 1'b0;
                     state_in    = pcar_pkg::ST_FINAL;
                  end
                  pcar_pkg::ACT_TERM: begin
                     count_in      = '0;
                     sum_in        = '0;
                     phase_in      = '0;
                     link_alive_in = 1'b0;
                     fin_ev_in     = pcar_pkg::EV_LINK_CLOSED;
                     fin_mend_in   = 1'b0;
                     state_in      = pcar_pkg::ST_FINAL;
                  end
                  default: begin
                     // Unused action codes are dropped.
                  end
               endcase
            end
         end
         pcar_pkg::ST_READ: begin
            // Fetch the next buffered byte; the registered read port presents it in ST_EMIT.
            if (len_ff == '0) begin
               state_in = pcar_pkg::ST_FINAL;
            end else begin
               rd_en    = 1'b1;
               state_in = pcar_pkg::ST_EMIT;
            end
         end
         pcar_pkg::ST_EMIT: begin
            // The read data stays put until the output register can take it.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               ev_in        = pcar_pkg::EV_DELIVER;
               byte_in      = rd_data;
               mend_in      = 1'b0;
               last_in      = 1'b0;
               idx_in       = idx_next;
               state_in     = (idx_next == len_ff) ? pcar_pkg::ST_FINAL : pcar_pkg::ST_READ;
            end
         end
         pcar_pkg::ST_FINAL: begin
            // The closing result of the transaction carries the run-last mark.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               ev_in        = fin_ev_ff;
               byte_in      = '0;
               mend_in      = fin_mend_ff;
               last_in      = 1'b1;
               state_in     = pcar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcar_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.event_res   = ev_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.message_end = mend_ff;
   assign rsp_ch.run_last    = last_ff;

endmodule

// ----- verif/tb_packet_checksum_ack_receiver.sv -----
// Self-checking testbench for the stop-and-wait packet checksum acknowledge receiver.
`timescale 1ns / 100ps

module tb_packet_checksum_ack_receiver;
   import pcar_pkg::*;

   // The buffer depth matches the default of the block and is passed to it explicitly.
   localparam int PAYLOAD_MAX     = 32;
   localparam int RANDOM_ITEMS    = 40;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   // The longest run of results is a full packet of delivered bytes plus the ack.
   localparam int DRAIN_CYCLES    = 2 * PAYLOAD_MAX + 16;
   localparam int LOW_WEIGHT      = 3;
   localparam logic [ACTION_W-1:0] ACT_CODE_MAX = '1;

   // How the checksum of a closing byte is formed: the true sum, a corrupted copy, or the
   // true sum with bits set above the width of the accumulator.
   typedef enum int {
      CSUM_GOOD,
      CSUM_CORRUPT,
      CSUM_UPPER_SET
   } csum_mode_type;

   typedef struct packed {
      event_type            event_res;
      logic [BYTE_W-1:0]    out_byte;
      logic                 message_end;
      logic                 run_last;
   } link_event_type;

   typedef logic [BYTE_W-1:0] byte_queue_type[$];

   logic clock;
   logic reset;

   pcar_req_if req_if ();
   pcar_rsp_if rsp_if ();

   packet_checksum_ack_receiver #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Mirror of the receiver state, updated once per accepted request transaction.
   logic                 link_open;
   logic [BYTE_W-1:0]    packet_buf [PAYLOAD_MAX];
   int unsigned          stored_count;
   logic [SUM_W-1:0]     running_sum;
   logic [PHASE_W-1:0]   group_pos;

   // Events the receiver still owes us, oldest first.
   link_event_type       pending_events[$];

   int unsigned          mismatch_count;
   int unsigned          items_accepted;
   bit                   idle_enabled;
   bit                   rsp_hold_request;

   // ---------------------------------------------------------------------------------------
   // Clock and reset. Reset is held high from the start and released on a falling edge.
   // ---------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor. Bytes one and two of each group of four are weighted by three, bytes three
   // and four are divided by three with truncation. A byte beyond the buffer depth is
   // dropped from both the buffer and the sum, but its last mark still closes the packet.
   // ---------------------------------------------------------------------------------------
   function automatic logic [SUM_W-1:0] weighted_byte(input logic [BYTE_W-1:0] b,
                                                      input logic [PHASE_W-1:0] pos);
      logic [SUM_W-1:0] wide;
      wide = SUM_W'(b);
      return (pos < 2) ? SUM_W'(wide * LOW_WEIGHT) : SUM_W'(wide / LOW_WEIGHT);
   endfunction

   // Checksum the packet would carry if b were its closing byte.
   function automatic logic [CHECKSUM_W-1:0] checksum_with(input logic [BYTE_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = running_sum;
      if (stored_count < PAYLOAD_MAX)
         s = s + weighted_byte(b, group_pos);
      return CHECKSUM_W'(s);
   endfunction

   function automatic void push_event(input event_type ev, input logic [BYTE_W-1:0] b,
                                      input logic mend, input logic last_mark);
      link_event_type e;
      e.event_res   = ev;
      e.out_byte    = b;
      e.message_end = mend;
      e.run_last    = last_mark;
      pending_events.push_back(e);
   endfunction

   function automatic void clear_open_packet();
      stored_count = 0;
      running_sum  = '0;
      group_pos    = '0;
   endfunction

   function automatic void predict_link_events(input logic [ACTION_W-1:0]   act,
                                               input logic [BYTE_W-1:0]     b,
                                               input logic                  last_mark,
                                               input logic [CHECKSUM_W-1:0] sent);
      logic [CHECKSUM_W-1:0] wide_sum;
      // A closed link swallows everything without a trace.
      if (!link_open)
         return;
      case (act)
         ACT_DATA, ACT_LAST_DATA: begin
            if (stored_count < PAYLOAD_MAX) begin
               packet_buf[stored_count] = b;
               running_sum  = running_sum + weighted_byte(b, group_pos);
               stored_count = stored_count + 1;
               group_pos    = group_pos + 1'b1;
            end
            if (last_mark) begin
               // The accumulator is zero-extended against all bits of the sent checksum.
               wide_sum = CHECKSUM_W'(running_sum);
               if (wide_sum == sent) begin
                  for (int i = 0; i < stored_count; i++)
                     push_event(EV_DELIVER, packet_buf[i], 1'b0, 1'b0);
                  // The kind of the closing byte alone decides the end of the message.
                  push_event(EV_SEND_ACK, '0, act == ACT_LAST_DATA, 1'b1);
               end else begin
                  push_event(EV_SEND_NACK, '0, 1'b0, 1'b1);
               end
               clear_open_packet();
            end
         end
         // Acks and nacks from the far end are reported and leave the open packet alone.
         ACT_ACK:  push_event(EV_ACK_SEEN, '0, 1'b0, 1'b1);
         ACT_NACK: push_event(EV_NACK_SEEN, '0, 1'b0, 1'b1);
         ACT_TERM: begin
            clear_open_packet();
            link_open = 1'b0;
            push_event(EV_LINK_CLOSED, '0, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Idle lengths for both sides: mostly none or short, now and then a long one. Turning
   // idle_enabled off gives stretches of back-to-back traffic.
   // ---------------------------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idle_enabled)
         return 0;
      r = $urandom_range(99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side. Fields change on the falling edge; a transaction is taken at the rising
   // edge where ready is high. Valid stays high into the next item when there is no gap, so
   // it is written only once per falling edge.
   // ---------------------------------------------------------------------------------------
   task automatic send_item(input logic [ACTION_W-1:0]   act,
                            input logic [BYTE_W-1:0]     b,
                            input logic                  last_mark,
                            input logic [CHECKSUM_W-1:0] sent);
      int unsigned gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.action        = act;
      req_if.data_byte     = b;
      req_if.byte_last     = last_mark;
      req_if.sent_checksum = sent;
      req_if.valid         = 1'b1;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      // Unused codes and traffic on a closed link do not count toward the random budget.
      if (act <= ACT_TERM && link_open)
         items_accepted++;
      predict_link_events(act, b, last_mark, sent);
   endtask

   // Drops valid so that a transaction already taken is not offered again while we wait.
   task automatic stop_offering();
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   // An ack, a nack or an unused action code with random payload fields.
   task automatic send_stray();
      logic [ACTION_W-1:0] act;
      int unsigned         r;
      r = $urandom_range(99);
      if (r < 40)
         act = ACT_ACK;
      else if (r < 80)
         act = ACT_NACK;
      else
         act = ACTION_W'($urandom_range(ACT_TERM + 1, ACT_CODE_MAX));
      send_item(act, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), $urandom());
   endtask

   // Sends one packet. Bytes before the last carry a random kind and random checksum, so
   // only the closing byte decides the kind and the compare. Stray acks, nacks and unused
   // codes are slipped between bytes with the given percentage.
   task automatic send_packet(input byte_queue_type      bytes_q,
                              input logic [ACTION_W-1:0] close_kind,
                              input csum_mode_type       mode,
                              input int unsigned         stray_pct);
      logic [CHECKSUM_W-1:0] sent;
      logic [CHECKSUM_W-1:0] flip;
      logic [ACTION_W-1:0]   kind;
      for (int i = 0; i < bytes_q.size(); i++) begin
         if ($urandom_range(99) < stray_pct)
            send_stray();
         if (i < bytes_q.size() - 1) begin
            kind = $urandom_range(1) ? ACT_LAST_DATA : ACT_DATA;
            send_item(kind, bytes_q[i], 1'b0, $urandom());
         end else begin
            sent = checksum_with(bytes_q[i]);
            case (mode)
               CSUM_CORRUPT: begin
                  do
                     flip = $urandom();
                  while (flip == '0);
                  sent = sent ^ flip;
               end
               CSUM_UPPER_SET: begin
                  flip = $urandom();
                  flip[SUM_W-1:0] = '0;
                  if (flip == '0)
                     flip[CHECKSUM_W-1] = 1'b1;
                  sent = sent | flip;
               end
               default: ;
            endcase
            send_item(close_kind, bytes_q[i], 1'b1, sent);
         end
      end
   endtask

   function automatic byte_queue_type random_bytes(input int unsigned len);
      byte_queue_type q;
      repeat (len)
         q.push_back(BYTE_W'($urandom_range(255)));
      return q;
   endfunction

   // Most packets are short; a few fill the buffer or run past it.
   function automatic int unsigned pick_packet_len();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 85)
         return $urandom_range(1, 6);
      if (r < 95)
         return $urandom_range(7, 16);
      return $urandom_range(PAYLOAD_MAX - 2, PAYLOAD_MAX + 2);
   endfunction

   function automatic csum_mode_type pick_csum_mode();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 75)
         return CSUM_GOOD;
      if (r < 93)
         return CSUM_CORRUPT;
      return CSUM_UPPER_SET;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Response side. Ready changes on the falling edge with random stalls. When a long
   // hold-off is requested, ready is held low so that the block fills up and has to stall
   // its input.
   // ---------------------------------------------------------------------------------------
   initial begin
      int unsigned stall_left;
      stall_left  = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_if.ready = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_request = 1'b0;
         end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            if (stall_left == 0) begin
               rsp_if.ready = 1'b1;
            end else begin
               rsp_if.ready = 1'b0;
               stall_left--;
            end
         end
      end
   end

   // Every response transaction is compared field by field with the oldest expected event.
   always @(posedge clock) begin
      link_event_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_events.size() == 0) begin
            $error("unexpected result: event_res %0d out_byte %0d", rsp_if.event_res,
                   rsp_if.out_byte);
            mismatch_count++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_if.event_res !== want.event_res) begin
               $error("event_res: expected %0d, actual %0d", want.event_res,
                      rsp_if.event_res);
               mismatch_count++;
            end
            if (rsp_if.out_byte !== want.out_byte) begin
               $error("out_byte: expected %0d, actual %0d", want.out_byte, rsp_if.out_byte);
               mismatch_count++;
            end
            if (rsp_if.message_end !== want.message_end) begin
               $error("message_end: expected %0d, actual %0d", want.message_end,
                      rsp_if.message_end);
               mismatch_count++;
            end
            if (rsp_if.run_last !== want.run_last) begin
               $error("run_last: expected %0d, actual %0d", want.run_last, rsp_if.run_last);
               mismatch_count++;
            end
         end
      end
   end

   // The watchdog counts cycles in which neither side completes a transaction. The limit
   // covers the long hold-off, the longest idle gaps and a full packet delivery.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // One-byte packets at the byte extremes: a zero sum that matches, a full byte closed by
   // either data kind, a corrupted checksum, and a matching low part with upper bits set,
   // which must be refused since the compare covers the whole checksum field.
   task automatic test_single_byte_packets();
      send_packet({8'd0}, ACT_LAST_DATA, CSUM_GOOD, 0);
      send_packet({8'd255}, ACT_DATA, CSUM_GOOD, 0);
      send_packet({8'd255}, ACT_LAST_DATA, CSUM_CORRUPT, 0);
      send_packet({8'd0}, ACT_LAST_DATA, CSUM_UPPER_SET, 0);
   endtask

   // Packets that walk through all four weights of a group and wrap into the next group,
   // with data kinds mixed inside the packet.
   task automatic test_checksum_groups();
      send_packet({8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, ACT_LAST_DATA, CSUM_GOOD, 0);
      send_packet({8'h80, 8'h01, 8'h7F, 8'hFE}, ACT_DATA, CSUM_GOOD, 0);
   endtask

   // Acks and nacks on an idle link and inside an open packet, plus the unused codes, which
   // must leave the packet intact so that it still closes with the right bytes.
   task automatic test_reports_inside_packet();
      send_item(ACT_ACK, 8'd0, 1'b0, '0);
      send_item(ACT_NACK, 8'd255, 1'b1, '1);
      send_item(ACT_DATA, 8'd17, 1'b0, '1);
      send_item(ACT_ACK, 8'd255, 1'b1, '0);
      send_item(ACT_NACK, 8'd0, 1'b0, '1);
      for (int code = ACT_TERM + 1; code <= ACT_CODE_MAX; code++)
         send_item(ACTION_W'(code), BYTE_W'($urandom_range(255)), 1'b1, $urandom());
      send_packet({8'd42, 8'd200}, ACT_LAST_DATA, CSUM_GOOD, 0);
   endtask

   // A packet that runs two bytes past the buffer: the extra bytes are neither kept nor
   // summed, and the final one still closes the packet with a full delivery.
   task automatic test_packet_overflow();
      send_packet(random_bytes(PAYLOAD_MAX + 2), ACT_LAST_DATA, CSUM_GOOD, 0);
   endtask

   // Mostly well-formed packets of random length, content and kind, with checksums that
   // mostly match, strays between bytes, and stretches with and without idling.
   task automatic test_random_traffic();
      int unsigned target;
      logic [ACTION_W-1:0] kind;
      target = items_accepted + RANDOM_ITEMS;
      while (items_accepted < target) begin
         if ($urandom_range(9) == 0)
            idle_enabled = !idle_enabled;
         if ($urandom_range(99) < 85) begin
            kind = $urandom_range(1) ? ACT_LAST_DATA : ACT_DATA;
            send_packet(random_bytes(pick_packet_len()), kind, pick_csum_mode(), 8);
         end else begin
            send_stray();
         end
      end
      idle_enabled = 1'b1;
   endtask

   // The receiver holds off while the sender keeps offering back-to-back packets, so the
   // block fills up and must stall its input until results drain again.
   task automatic test_backpressure();
      idle_enabled     = 1'b0;
      rsp_hold_request = 1'b1;
      repeat (3)
         send_packet(random_bytes(6), ACT_LAST_DATA, CSUM_GOOD, 0);
      stop_offering();
      while (rsp_hold_request)
         @(posedge clock);
      idle_enabled = 1'b1;
   endtask

   // Terminate in the middle of a packet closes the link; everything after it, including
   // closing bytes and another terminate, is accepted and produces nothing.
   task automatic test_terminate();
      send_item(ACT_DATA, 8'd9, 1'b0, '0);
      send_item(ACT_LAST_DATA, 8'd77, 1'b0, '0);
      send_item(ACT_TERM, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), $urandom());
      send_item(ACT_LAST_DATA, 8'd0, 1'b1, '0);
      send_item(ACT_TERM, 8'd0, 1'b0, '0);
      repeat (10)
         send_item(ACTION_W'($urandom_range(ACT_CODE_MAX)), BYTE_W'($urandom_range(255)),
                   1'($urandom_range(1)), $urandom());
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence of the run.
   // ---------------------------------------------------------------------------------------
   initial begin
      req_if.valid         = 1'b0;
      req_if.action        = ACT_DATA;
      req_if.data_byte     = '0;
      req_if.byte_last     = 1'b0;
      req_if.sent_checksum = '0;
      reset                = 1'b1;
      mismatch_count       = 0;
      items_accepted       = 0;
      idle_enabled         = 1'b1;
      rsp_hold_request     = 1'b0;
      link_open            = 1'b1;
      clear_open_packet();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_byte_packets();
      test_checksum_groups();
      test_reports_inside_packet();
      test_packet_overflow();
      test_random_traffic();
      test_backpressure();
      test_terminate();

      // Let every owed result arrive, then watch a while longer for stray output.
      stop_offering();
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/pcar_pkg.sv
rtl/core/pcar_if.sv
rtl/core/pcar_ram.sv
rtl/core/pcar_csum.sv
rtl/core/packet_checksum_ack_receiver.sv
verif/tb_packet_checksum_ack_receiver.sv
